// ===== rtl/ois_pkg.sv =====
package ois_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned COUNT_OUT_W  = 5;
  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned IN_TDATA_W   = 40;
  localparam int unsigned OUT_TDATA_W  = 40;

  // Default number of entries in the store
  localparam int unsigned CAPACITY_DEF = 16;

  // Oldest value reported for an empty set
  localparam logic signed [DATA_W-1:0] EMPTY_OLDEST = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD      = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_CONTAINS = 2'd2,
    ACT_CHOOSE   = 2'd3
  } action_e;

  typedef struct packed {
    logic                       success;
    logic signed [DATA_W-1:0]   oldest_value;
    logic [COUNT_OUT_W-1:0]     member_count;
  } result_t;

endpackage

// ===== rtl/ordered_integer_set.sv =====
// Ordered integer set: a store of up to CAPACITY distinct signed 32-bit values,
// kept in insertion order, oldest first.
// Input stream s_axis: one transfer carries an action (add, remove, contains,
// choose) and an operand value. Output stream m_axis: exactly one result per
// input transfer, in order: success flag, oldest value after the action (-1 when
// empty) and the member count after the action, masked to 5 bits.
// The transfer edge loads the input register; the item moves on into the result
// register once that register frees up, and m_axis is driven from there.
// Throughput: one item per cycle unless m_axis stalls. Actions are combinational:
// a parallel compare of all entries; on remove, one-place shift of younger ones.
// Reset empties the set; stored values are cleared logically through the count.
// When the receiver stalls, the result register holds its result and the input
// register holds one more item; s_axis_tready drops only when both are full.
module ordered_integer_set #(
  parameter int unsigned CAPACITY = ois_pkg::CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] action, [33:2] operand_value, [39:34] zero
  input  logic [ois_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] success, [32:1] oldest_value, [37:33] member_count, [39:38] zero
  output logic [ois_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned ResW = $bits(ois_pkg::result_t);

  logic                              in_valid_q;
  logic                              in_valid_d;
  ois_pkg::action_e                  in_action_q;
  logic signed [ois_pkg::DATA_W-1:0] in_value_q;
  logic                              out_valid_q;
  logic                              out_valid_d;
  ois_pkg::result_t                  out_result_q;
  ois_pkg::result_t                  result;
  logic                              in_fire;
  logic                              advance;

  // Move the held item into the result register when that register frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input transfer and the finished result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_action_q <= ois_pkg::action_e'(s_axis_tdata[ois_pkg::ACTION_W-1:0]);
      in_value_q  <= s_axis_tdata[ois_pkg::ACTION_W +: ois_pkg::DATA_W];
    end
    if (advance) begin
      out_result_q <= result;
    end
  end

  ois_store #(
    .Capacity (CAPACITY)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .action_i (in_action_q),
    .value_i  (in_value_q),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ois_pkg::OUT_TDATA_W - ResW){1'b0}},
                          out_result_q.member_count,
                          out_result_q.oldest_value,
                          out_result_q.success};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced item did not reach the result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_value_q))
    else $error("held input item lost while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled with room available");

endmodule

// ===== rtl/ois_store.sv =====
module ois_store #(
  parameter int unsigned Capacity = ois_pkg::CAPACITY_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 fire_i,
  input  ois_pkg::action_e                     action_i,
  input  logic signed [ois_pkg::DATA_W-1:0]    value_i,
  output ois_pkg::result_t                     result_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic signed [ois_pkg::DATA_W-1:0] entries_q [Capacity];
  logic signed [ois_pkg::DATA_W-1:0] entries_d [Capacity];
  logic [CntW-1:0]                   count_q;
  logic [CntW-1:0]                   count_d;

  logic [Capacity-1:0] match;
  logic [Capacity-1:0] at_or_after;
  logic                present;
  logic                full;
  logic                add_ok;
  logic                rem_ok;
  logic                success;

  // Compare every live entry against the operand; mark the hit and all younger slots
  always_comb begin
    logic run;
    run = 1'b0;
    for (int i = 0; i < Capacity; i++) begin
      match[i]       = (CntW'(i) < count_q) && (entries_q[i] == value_i);
      run            = run | match[i];
      at_or_after[i] = run;
    end
    present = run;
  end

  assign full   = (count_q == CntW'(Capacity));
  assign add_ok = (action_i == ois_pkg::ACT_ADD) && !present && !full;
  assign rem_ok = (action_i == ois_pkg::ACT_REMOVE) && present;

  // Append at the tail on add, shift younger entries down on remove
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      entries_d[i] = entries_q[i];
      if (add_ok && (count_q == CntW'(i))) begin
        entries_d[i] = value_i;
      end
    end
    for (int i = 0; i < Capacity - 1; i++) begin
      if (rem_ok && at_or_after[i]) begin
        entries_d[i] = entries_q[i + 1];
      end
    end
    count_d = count_q;
    if (add_ok) begin
      count_d = count_q + CntW'(1);
    end else if (rem_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Decode the success flag per action
  always_comb begin
    unique case (action_i)
      ois_pkg::ACT_ADD:      success = add_ok;
      ois_pkg::ACT_REMOVE:   success = rem_ok;
      ois_pkg::ACT_CONTAINS: success = present;
      ois_pkg::ACT_CHOOSE:   success = (count_q != '0);
    endcase
  end

  assign result_o.success      = success;
  assign result_o.oldest_value = (count_d != '0) ? entries_d[0] : ois_pkg::EMPTY_OLDEST;
  assign result_o.member_count = ois_pkg::COUNT_OUT_W'(count_d);

  // Hold the count across idle cycles, update on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
    end
  end

  // Store payload needs no reset; entries above the count are never read
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      for (int i = 0; i < Capacity; i++) begin
        entries_q[i] <= entries_d[i];
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("member count exceeds capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && add_ok |=> count_q == $past(count_q) + CntW'(1))
    else $error("successful add did not grow the count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && rem_ok |=> count_q == $past(count_q) - CntW'(1))
    else $error("successful remove did not shrink the count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (action_i == ois_pkg::ACT_CONTAINS || action_i == ois_pkg::ACT_CHOOSE)
    |=> $stable(count_q))
    else $error("query changed the member count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("value stored in more than one slot");

endmodule
